// ----- design/hblm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hblm_pkg
// Shared constants and types for the heartbeat liveness monitor.
// ----------------------------------------------------------------------------
package hblm_pkg;

    localparam int COUNT_BITS   = 32;
    localparam int TIME_BITS    = 48;
    localparam int TIMEOUT_BITS = 32;
    localparam int CMP_BITS     = (TIME_BITS > TIMEOUT_BITS) ? TIME_BITS : TIMEOUT_BITS;

    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(1000);
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_MIN   = TIMEOUT_BITS'(1);

    localparam logic [1:0] ST_WAITING   = 2'd0;
    localparam logic [1:0] ST_CONNECTED = 2'd1;
    localparam logic [1:0] ST_LOST      = 2'd2;
    localparam logic [1:0] ST_CLOSED    = 2'd3;

    typedef struct packed {
        logic [1:0]            link_state;
        logic [TIME_BITS-1:0]  last_activity_time;
        logic                  activity_seen;
        logic [COUNT_BITS-1:0] last_packet_total;
        logic                  total_seen;
        logic                  pending_disconnect;
    } mon_state_t;

    localparam mon_state_t MON_STATE_RESET = '{
        link_state:         ST_WAITING,
        last_activity_time: '0,
        activity_seen:      1'b0,
        last_packet_total:  '0,
        total_seen:         1'b0,
        pending_disconnect: 1'b0
    };

    typedef struct packed {
        logic [1:0] conn_state;
        logic       disconnect_flag;
    } mon_result_t;

endpackage

// ----- design/hblm_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hblm_update
// Next-state and result logic for one observation of the link partner.
// ----------------------------------------------------------------------------
module hblm_update
(
    input  hblm_pkg::mon_state_t                 cur,
    input  logic [hblm_pkg::TIMEOUT_BITS-1:0]    timeout_ticks,
    input  logic                                 rearm,
    input  logic [hblm_pkg::COUNT_BITS-1:0]      packet_total,
    input  logic                                 closing,
    input  logic [hblm_pkg::TIME_BITS-1:0]       now_ticks,
    input  logic                                 consume,
    output hblm_pkg::mon_state_t                 nxt,
    output hblm_pkg::mon_result_t                res
);

    logic                              total_changed;
    logic                              activity;
    logic [1:0]                        st_act;
    logic [1:0]                        st_close;
    logic [hblm_pkg::TIME_BITS-1:0]    la_close;
    logic                              as_close;
    logic                              pd_close;
    logic [hblm_pkg::TIME_BITS-1:0]    elapsed;
    logic                              timed_out;
    logic [1:0]                        st_final;
    logic                              pd_final;

    always_comb
    begin
        total_changed = !cur.total_seen || (packet_total != cur.last_packet_total);
        activity      = total_changed &&
                        (cur.total_seen ? (packet_total > cur.last_packet_total)
                                        : (packet_total != '0));

        st_act = cur.link_state;
        if (activity && (cur.link_state == hblm_pkg::ST_WAITING ||
                         cur.link_state == hblm_pkg::ST_LOST))
        begin
            st_act = hblm_pkg::ST_CONNECTED;
        end

        st_close = st_act;
        la_close = (activity || closing) ? now_ticks : cur.last_activity_time;
        as_close = cur.activity_seen || activity || closing;
        pd_close = cur.pending_disconnect;
        if (closing && st_act != hblm_pkg::ST_CLOSED)
        begin
            st_close = hblm_pkg::ST_CLOSED;
            pd_close = 1'b1;
        end

        // backwards time never times out
        elapsed   = now_ticks - la_close;
        timed_out = (st_close == hblm_pkg::ST_CONNECTED) && as_close &&
                    (now_ticks >= la_close) &&
                    (hblm_pkg::CMP_BITS'(elapsed) > hblm_pkg::CMP_BITS'(timeout_ticks));

        st_final = timed_out ? hblm_pkg::ST_LOST : st_close;
        pd_final = pd_close || timed_out;

        if (rearm)
        begin
            nxt                 = hblm_pkg::MON_STATE_RESET;
            res.conn_state      = hblm_pkg::ST_WAITING;
            res.disconnect_flag = 1'b0;
        end
        else
        begin
            nxt.link_state         = st_final;
            nxt.last_activity_time = la_close;
            nxt.activity_seen      = as_close;
            nxt.last_packet_total  = total_changed ? packet_total : cur.last_packet_total;
            nxt.total_seen         = 1'b1;
            nxt.pending_disconnect = pd_final && !consume;
            res.conn_state         = st_final;
            res.disconnect_flag    = pd_final;
        end
    end

endmodule

// ----- design/heartbeat_liveness_monitor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_liveness_monitor_top
// Heartbeat timeout watchdog: tracks link activity, close and timeout.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    rearm, packet_total, closing, now_ticks, consume
//  out      out_valid/out_ready  conn_state, disconnect_flag
//  cfg      cfg_we               cfg_wdata (timeout_ticks, zero stored as one)
//
//  One transaction per cycle while in_ready is high; its result is registered.
//  The rate is set by the combinational state update (48-bit subtract/compare).
//  Reset returns to waiting with a timeout of 1000 ticks.
//  in_ready drops only while a result is held and out_ready is low.
// ----------------------------------------------------------------------------
module heartbeat_liveness_monitor_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hblm_pkg::TIMEOUT_BITS-1:0]   cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                rearm,
    input  logic [hblm_pkg::COUNT_BITS-1:0]     packet_total,
    input  logic                                closing,
    input  logic [hblm_pkg::TIME_BITS-1:0]      now_ticks,
    input  logic                                consume,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          conn_state,
    output logic                                disconnect_flag
);

    hblm_pkg::mon_state_t                state_reg;
    hblm_pkg::mon_state_t                state_next;
    hblm_pkg::mon_result_t               result_reg;
    hblm_pkg::mon_result_t               result_next;
    logic [hblm_pkg::TIMEOUT_BITS-1:0]   timeout_reg;
    logic                                out_valid_reg;
    logic                                accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    hblm_update u_update
    (
        .cur           (state_reg),
        .timeout_ticks (timeout_reg),
        .rearm         (rearm),
        .packet_total  (packet_total),
        .closing       (closing),
        .now_ticks     (now_ticks),
        .consume       (consume),
        .nxt           (state_next),
        .res           (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hblm_pkg::MON_STATE_RESET;
            timeout_reg   <= hblm_pkg::TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= (cfg_wdata == '0) ? hblm_pkg::TIMEOUT_MIN : cfg_wdata;
            end
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign conn_state      = result_reg.conn_state;
    assign disconnect_flag = result_reg.disconnect_flag;

    a_rearm_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && rearm |=> out_valid && conn_state == hblm_pkg::ST_WAITING &&
                            !disconnect_flag)
        else $error("rearm did not return to waiting");

    a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !rearm && state_reg.link_state == hblm_pkg::ST_CLOSED
        |=> state_reg.link_state == hblm_pkg::ST_CLOSED)
        else $error("closed state left without rearm");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid && conn_state == $past(result_next.conn_state))
        else $error("accepted transaction lost its result");

    a_timeout_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        timeout_reg != '0)
        else $error("timeout register holds zero");

endmodule

// ----- tb/heartbeat_liveness_monitor_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heartbeat_liveness_monitor_top_tb
// Self-checking bench for the heartbeat liveness monitor. A short stimulus
// table covers activity, falling totals, close, timeout edges, backwards time
// and rearm. Random phases follow, each with its own timeout and a flow-control
// mix. An in-bench predictor tracks the link state per transaction, and every
// result is compared in order against it or, for typed rows, the table value.
// ----------------------------------------------------------------------------
module heartbeat_liveness_monitor_top_tb;
    import hblm_pkg::*;

    typedef struct packed {
        logic                  rearm;
        logic [COUNT_BITS-1:0] packet_total;
        logic                  closing;
        logic [TIME_BITS-1:0]  now_ticks;
        logic                  consume;
    } beat_t;

    typedef struct {
        beat_t       beat;
        bit          typed;
        mon_result_t want;
    } table_row_t;

    localparam logic [COUNT_BITS-1:0] TOTAL_MAX   = '1;
    localparam logic [TIME_BITS-1:0]  NOW_MAX     = '1;
    localparam int                    NUM_PHASES  = 7;
    localparam int                    HOLD_CYCLES = 120;
    localparam int                    DRAIN_LIMIT = 5000;
    localparam int                    PRINT_LIMIT = 100;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    cfg_we       = 1'b0;
    logic [TIMEOUT_BITS-1:0] cfg_wdata    = '0;
    logic                    in_valid     = 1'b0;
    logic                    in_ready;
    logic                    rearm        = 1'b0;
    logic [COUNT_BITS-1:0]   packet_total = '0;
    logic                    closing      = 1'b0;
    logic [TIME_BITS-1:0]    now_ticks    = '0;
    logic                    consume      = 1'b0;
    logic                    out_valid;
    logic                    out_ready    = 1'b0;
    logic [1:0]              conn_state;
    logic                    disconnect_flag;

    mon_state_t              link_mirror    = MON_STATE_RESET;
    logic [TIMEOUT_BITS-1:0] timeout_shadow = TIMEOUT_RESET;
    mon_result_t             awaited_status[$];
    table_row_t              directed_rows[$];
    int                      mismatch_count = 0;
    int                      idle_pct       = 0;
    int                      stall_pct      = 0;
    int                      hold_asks      = 0;
    int                      hold_seen      = 0;
    int                      hold_left      = 0;
    logic [TIME_BITS-1:0]    gen_now        = '0;
    logic [COUNT_BITS-1:0]   gen_total      = '0;

    logic [TIMEOUT_BITS-1:0] ph_timeout [NUM_PHASES] = '{
        TIMEOUT_BITS'(0), TIMEOUT_BITS'(1), TIMEOUT_BITS'(32'hFFFF_FFFF),
        TIMEOUT_BITS'(1000), TIMEOUT_BITS'(0), TIMEOUT_BITS'(0), TIMEOUT_BITS'(50)
    };
    int ph_idle  [NUM_PHASES] = '{0, 47, 0, 11, 47, 0, 0};
    int ph_stall [NUM_PHASES] = '{0, 0, 47, 11, 0, 47, 0};
    int ph_items [NUM_PHASES] = '{280, 250, 250, 300, 280, 250, 300};
    bit ph_press [NUM_PHASES] = '{0, 0, 0, 1, 0, 0, 1};

    heartbeat_liveness_monitor_top DUT
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rearm           (rearm),
        .packet_total    (packet_total),
        .closing         (closing),
        .now_ticks       (now_ticks),
        .consume         (consume),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .conn_state      (conn_state),
        .disconnect_flag (disconnect_flag)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // One observation through the watchdog; updates the mirrored state.
    function automatic mon_result_t liveness_step(input beat_t b);
        mon_result_t r;
        if (b.rearm)
        begin
            link_mirror       = MON_STATE_RESET;
            r.conn_state      = ST_WAITING;
            r.disconnect_flag = 1'b0;
            return r;
        end
        if (!link_mirror.total_seen || b.packet_total != link_mirror.last_packet_total)
        begin
            if (link_mirror.total_seen ? (b.packet_total > link_mirror.last_packet_total)
                                       : (b.packet_total != '0))
            begin
                link_mirror.last_activity_time = b.now_ticks;
                link_mirror.activity_seen      = 1'b1;
                if (link_mirror.link_state == ST_WAITING || link_mirror.link_state == ST_LOST)
                    link_mirror.link_state = ST_CONNECTED;
            end
            link_mirror.last_packet_total = b.packet_total;
            link_mirror.total_seen        = 1'b1;
        end
        if (b.closing)
        begin
            link_mirror.last_activity_time = b.now_ticks;
            link_mirror.activity_seen      = 1'b1;
            if (link_mirror.link_state != ST_CLOSED)
            begin
                link_mirror.link_state         = ST_CLOSED;
                link_mirror.pending_disconnect = 1'b1;
            end
        end
        if (link_mirror.link_state == ST_CONNECTED && link_mirror.activity_seen &&
            b.now_ticks >= link_mirror.last_activity_time &&
            CMP_BITS'(b.now_ticks - link_mirror.last_activity_time) >
            CMP_BITS'(timeout_shadow))
        begin
            link_mirror.link_state         = ST_LOST;
            link_mirror.pending_disconnect = 1'b1;
        end
        r.conn_state      = link_mirror.link_state;
        r.disconnect_flag = link_mirror.pending_disconnect;
        if (b.consume)
            link_mirror.pending_disconnect = 1'b0;
        return r;
    endfunction

    // Mostly well-formed heartbeat traffic scaled to the current timeout; some noise.
    function automatic beat_t draw_beat();
        beat_t       b;
        logic [63:0] step;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            b.rearm        = ($urandom_range(7) == 0);
            b.packet_total = $urandom;
            b.closing      = ($urandom_range(7) == 0);
            b.now_ticks    = TIME_BITS'({$urandom, $urandom});
            b.consume      = 1'($urandom_range(1));
            gen_total      = b.packet_total;
            gen_now        = b.now_ticks;
            return b;
        end
        pick = $urandom_range(99);
        if (pick < 50)
            step = 64'($urandom_range(timeout_shadow / 4));
        else if (pick < 78)
        begin
            step = 64'(timeout_shadow) + 64'($urandom_range(4));
            step = (step >= 2) ? step - 2 : 64'd0;
        end
        else if (pick < 92)
            step = 64'($urandom_range(3));
        else
            step = 64'd0;
        if (pick >= 92)
        begin
            step    = 64'($urandom_range(timeout_shadow));
            gen_now = (64'(gen_now) > step) ? gen_now - TIME_BITS'(step) : '0;
        end
        else
            gen_now = gen_now + TIME_BITS'(step);

        pick = $urandom_range(99);
        if (pick < 55)
            ;
        else if (pick < 85)
            gen_total = gen_total + COUNT_BITS'($urandom_range(3, 1));
        else if (pick < 92)
            gen_total = gen_total - COUNT_BITS'($urandom_range(5, 1));
        else if (pick < 96)
            gen_total = gen_total + COUNT_BITS'($urandom);
        else
            gen_total = '0;

        b.rearm        = ($urandom_range(99) < 3);
        b.closing      = ($urandom_range(199) < 3);
        b.consume      = ($urandom_range(99) < 35);
        b.packet_total = gen_total;
        b.now_ticks    = gen_now;
        if (b.rearm && $urandom_range(1))
            gen_total = '0;
        return b;
    endfunction

    function automatic void table_row(input logic r, input logic [COUNT_BITS-1:0] total,
                                      input logic cl, input logic [TIME_BITS-1:0] now,
                                      input logic cons, input bit typed,
                                      input logic [1:0] st, input logic flag);
        table_row_t row;
        row.beat.rearm             = r;
        row.beat.packet_total      = total;
        row.beat.closing           = cl;
        row.beat.now_ticks         = now;
        row.beat.consume           = cons;
        row.typed                  = typed;
        row.want.conn_state        = st;
        row.want.disconnect_flag   = flag;
        directed_rows.push_back(row);
    endfunction

    // Called and returns at a falling edge.
    task automatic send_beat(input beat_t b, input bit typed, input mon_result_t want);
        mon_result_t pred;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid     <= 1'b0;
            rearm        <= 1'($urandom_range(1));
            packet_total <= $urandom;
            closing      <= 1'($urandom_range(1));
            now_ticks    <= TIME_BITS'({$urandom, $urandom});
            consume      <= 1'($urandom_range(1));
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        rearm        <= b.rearm;
        packet_total <= b.packet_total;
        closing      <= b.closing;
        now_ticks    <= b.now_ticks;
        consume      <= b.consume;
        do
            @(posedge clk);
        while (!in_ready);
        pred = liveness_step(b);
        awaited_status.push_back(typed ? want : pred);
        @(negedge clk);
    endtask

    // Receiver side: random stall, or a long hold-off when requested.
    always @(negedge clk)
    begin
        if (hold_seen != hold_asks)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        mon_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_status.size() == 0)
                note_mismatch($sformatf("unexpected transaction: state %0d flag %0b",
                                        conn_state, disconnect_flag));
            else
            begin
                want = awaited_status.pop_front();
                if (conn_state !== want.conn_state)
                    note_mismatch($sformatf("conn_state %0d, want %0d",
                                            conn_state, want.conn_state));
                if (disconnect_flag !== want.disconnect_flag)
                    note_mismatch($sformatf("disconnect_flag %0b, want %0b",
                                            disconnect_flag, want.disconnect_flag));
            end
        end
    end

    initial
    begin
        #(64'd8 * 64'd400000);
        $display("heartbeat_liveness_monitor_top verification failed");
        $finish;
    end

    initial
    begin
        logic [TIMEOUT_BITS-1:0] wval;
        int                      drained;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // rearm  total      close  now      consume  typed  expected
        table_row(0, 0,         0, 0,       0, 1, ST_WAITING,   0);
        table_row(0, 5,         0, 100,     0, 1, ST_CONNECTED, 0);
        table_row(0, 5,         0, 1100,    0, 0, ST_WAITING,   0);
        table_row(0, 5,         0, 1101,    0, 0, ST_WAITING,   0);
        table_row(0, 5,         0, 1102,    1, 0, ST_WAITING,   0);
        table_row(0, 5,         0, 1103,    0, 0, ST_WAITING,   0);
        table_row(0, 4,         0, 1200,    0, 0, ST_WAITING,   0);
        table_row(0, 6,         0, 1300,    0, 0, ST_WAITING,   0);
        table_row(0, 6,         0, 50,      0, 0, ST_WAITING,   0);
        table_row(0, 6,         1, 1400,    0, 0, ST_WAITING,   0);
        table_row(0, 6,         1, 1401,    1, 0, ST_WAITING,   0);
        table_row(0, 6,         1, 1402,    0, 0, ST_WAITING,   0);
        table_row(0, 7,         0, 1403,    0, 0, ST_WAITING,   0);
        table_row(1, TOTAL_MAX, 1, NOW_MAX, 1, 1, ST_WAITING,   0);
        table_row(0, TOTAL_MAX, 0, NOW_MAX, 0, 1, ST_CONNECTED, 0);
        table_row(0, TOTAL_MAX, 0, 0,       0, 0, ST_WAITING,   0);
        table_row(1, 0,         0, 0,       0, 1, ST_WAITING,   0);
        table_row(0, 0,         0, NOW_MAX, 0, 1, ST_WAITING,   0);
        table_row(0, 0,         1, 0,       1, 1, ST_CLOSED,    1);
        table_row(0, 3,         1, 5,       0, 0, ST_WAITING,   0);
        table_row(1, 0,         1, 0,       1, 1, ST_WAITING,   0);
        table_row(0, 9,         1, 200,     0, 0, ST_WAITING,   0);
        table_row(0, 9,         0, 5000,    1, 0, ST_WAITING,   0);
        table_row(1, 9,         0, 5000,    0, 1, ST_WAITING,   0);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        ph_timeout[4] = $urandom_range(5000, 2);
        ph_timeout[5] = $urandom;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            in_valid <= 1'b0;
            while (awaited_status.size() != 0)
                @(posedge clk);
            @(negedge clk);
            wval           = ph_timeout[p];
            cfg_we        <= 1'b1;
            cfg_wdata     <= wval;
            timeout_shadow = (wval == '0) ? TIMEOUT_MIN : wval;
            @(negedge clk);
            cfg_we    <= 1'b0;
            idle_pct   = ph_idle[p];
            stall_pct  = ph_stall[p];
            if (ph_press[p])
                hold_asks++;
            for (int n = 0; n < ph_items[p]; n++)
                send_beat(draw_beat(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        drained = 0;
        while (awaited_status.size() != 0 && drained < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drained++;
        end
        repeat (4) @(posedge clk);
        if (awaited_status.size() != 0)
            note_mismatch($sformatf("%0d transactions never returned", awaited_status.size()));

        if (mismatch_count == 0)
            $display("heartbeat_liveness_monitor_top verification clean");
        else
            $display("heartbeat_liveness_monitor_top verification failed");
        $finish;
    end

endmodule

// ----- heartbeat_liveness_monitor_top.f -----
design/hblm_pkg.sv
design/hblm_update.sv
design/heartbeat_liveness_monitor_top.sv
tb/heartbeat_liveness_monitor_top_tb.sv
